// ===== hdl/lts_pkg.sv =====
// ----------------------------------------------------------------------------
// lts_pkg: shared types and constants of the lever trial sequencer
// Configuration layout, item and result structs, state and code names.
// ----------------------------------------------------------------------------
package lts_pkg;

    // Default parameter values
    localparam int DEF_TIME_BITS = 32;
    localparam int DEF_POS_BITS  = 32;

    // Field widths of the item and result
    localparam int NOW_W    = 32;
    localparam int POS_W    = 32;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int S_DATA_W = 80;
    localparam int M_DATA_W = 72;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GO_THRESHOLD    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EARLY_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_MS         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GO_TIMEOUT_MS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PENALTY_MS      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REST_WAIT_MS    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CUE_SOUND_MS    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_REWARD_PHASE_MS = 3'd7;

    // Register reset values
    localparam logic [CFG_W-1:0] RST_GO_THRESHOLD    = 16'hFFE5;  // -27
    localparam logic [CFG_W-1:0] RST_EARLY_THRESHOLD = 16'hFFF7;  // -9
    localparam logic [CFG_W-1:0] RST_HOLD_MS         = 16'd150;
    localparam logic [CFG_W-1:0] RST_GO_TIMEOUT_MS   = 16'd2500;
    localparam logic [CFG_W-1:0] RST_PENALTY_MS      = 16'd2000;
    localparam logic [CFG_W-1:0] RST_REST_WAIT_MS    = 16'd1500;
    localparam logic [CFG_W-1:0] RST_CUE_SOUND_MS    = 16'd500;
    localparam logic [CFG_W-1:0] RST_REWARD_PHASE_MS = 16'd500;

    // Fixed timings in ms
    localparam logic [CFG_W-1:0] INIT_WAIT_MS     = 16'd250;
    localparam logic [8:0]       CUE_DELAY_BASE   = 9'd250;
    localparam logic [7:0]       CUE_DELAY_SPAN   = 8'd200;
    localparam logic [CFG_W-1:0] GO_TONE_MS       = 16'd100;
    localparam logic [CFG_W-1:0] RESULT_SOUND_MS  = 16'd500;
    localparam logic [CFG_W-1:0] TIMEOUT_STATE_MS = 16'd500;

    // Reported state codes
    localparam logic [2:0] TS_INIT    = 3'd0;
    localparam logic [2:0] TS_CUE     = 3'd1;
    localparam logic [2:0] TS_GO      = 3'd2;
    localparam logic [2:0] TS_REWARD  = 3'd3;
    localparam logic [2:0] TS_PENALTY = 3'd4;
    localparam logic [2:0] TS_TIMEOUT = 3'd5;
    localparam logic [2:0] TS_RESET   = 3'd6;

    // Tone codes
    localparam logic [2:0] TONE_OFF     = 3'd0;
    localparam logic [2:0] TONE_GO      = 3'd4;
    localparam logic [2:0] TONE_REWARD  = 3'd5;
    localparam logic [2:0] TONE_PENALTY = 3'd6;
    localparam logic [2:0] TONE_TIMEOUT = 3'd7;

    localparam logic [1:0] GRATING_NONE = 2'd0;

    // Outcome codes
    localparam logic [1:0] OUT_CORRECT = 2'd0;
    localparam logic [1:0] OUT_TIMEOUT = 2'd1;
    localparam logic [1:0] OUT_EARLY   = 2'd2;

    // Torque request codes
    localparam logic [1:0] TQ_NONE = 2'd0;
    localparam logic [1:0] TQ_LOW  = 2'd1;
    localparam logic [1:0] TQ_HIGH = 2'd2;

    typedef enum logic [6:0] {
        ST_INIT    = 7'b0000001,
        ST_CUE     = 7'b0000010,
        ST_GO      = 7'b0000100,
        ST_REWARD  = 7'b0001000,
        ST_PENALTY = 7'b0010000,
        ST_TIMEOUT = 7'b0100000,
        ST_RESET   = 7'b1000000
    } state_t;

    typedef struct packed {
        logic [CFG_W-1:0] go_threshold;
        logic [CFG_W-1:0] early_threshold;
        logic [CFG_W-1:0] hold_ms;
        logic [CFG_W-1:0] go_timeout_ms;
        logic [CFG_W-1:0] penalty_ms;
        logic [CFG_W-1:0] rest_wait_ms;
        logic [CFG_W-1:0] cue_sound_ms;
        logic [CFG_W-1:0] reward_phase_ms;
    } cfg_t;

    typedef struct packed {
        logic [NOW_W-1:0] now_ms;
        logic [POS_W-1:0] position;
        logic [1:0]       random_type;
        logic [7:0]       random_delay;
    } item_t;

    typedef struct packed {
        logic [2:0]       trial_state;
        logic             reward_pin;
        logic [2:0]       tone_code;
        logic [1:0]       grating_code;
        logic             indicator_on;
        logic             lever_lock;
        logic [1:0]       torque_cmd;
        logic             report_valid;
        logic [1:0]       outcome;
        logic [15:0]      reaction_ms;
        logic [POS_W-1:0] report_position;
        logic [1:0]       report_level;
    } result_t;

    // Map the one-hot state to its reported code
    function automatic logic [2:0] state_code(input state_t st);
        logic [2:0] code;
        unique case (st)
            ST_INIT:    code = TS_INIT;
            ST_CUE:     code = TS_CUE;
            ST_GO:      code = TS_GO;
            ST_REWARD:  code = TS_REWARD;
            ST_PENALTY: code = TS_PENALTY;
            ST_TIMEOUT: code = TS_TIMEOUT;
            ST_RESET:   code = TS_RESET;
            default:    code = TS_INIT;
        endcase
        return code;
    endfunction

endpackage

// ===== hdl/lts_cfg.sv =====
// ----------------------------------------------------------------------------
// lts_cfg: configuration register file
// Eight 16-bit registers written through a plain write port, no read-back.
// ----------------------------------------------------------------------------
module lts_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [lts_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lts_pkg::CFG_W-1:0]     cfg_wdata,
    output lts_pkg::cfg_t                 cfg
);
    import lts_pkg::*;

    cfg_t cfg_reg;

    // Load defaults on reset, update the addressed register on a write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.go_threshold    <= RST_GO_THRESHOLD;
            cfg_reg.early_threshold <= RST_EARLY_THRESHOLD;
            cfg_reg.hold_ms         <= RST_HOLD_MS;
            cfg_reg.go_timeout_ms   <= RST_GO_TIMEOUT_MS;
            cfg_reg.penalty_ms      <= RST_PENALTY_MS;
            cfg_reg.rest_wait_ms    <= RST_REST_WAIT_MS;
            cfg_reg.cue_sound_ms    <= RST_CUE_SOUND_MS;
            cfg_reg.reward_phase_ms <= RST_REWARD_PHASE_MS;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_GO_THRESHOLD:    cfg_reg.go_threshold    <= cfg_wdata;
                REG_EARLY_THRESHOLD: cfg_reg.early_threshold <= cfg_wdata;
                REG_HOLD_MS:         cfg_reg.hold_ms         <= cfg_wdata;
                REG_GO_TIMEOUT_MS:   cfg_reg.go_timeout_ms   <= cfg_wdata;
                REG_PENALTY_MS:      cfg_reg.penalty_ms      <= cfg_wdata;
                REG_REST_WAIT_MS:    cfg_reg.rest_wait_ms    <= cfg_wdata;
                REG_CUE_SOUND_MS:    cfg_reg.cue_sound_ms    <= cfg_wdata;
                REG_REWARD_PHASE_MS: cfg_reg.reward_phase_ms <= cfg_wdata;
                default:             cfg_reg.go_threshold    <= cfg_reg.go_threshold;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/lts_core.sv =====
// ----------------------------------------------------------------------------
// lts_core: trial state machine
// Holds the trial state and computes the next state and the result of one
// tick in a single pass of logic.
// ----------------------------------------------------------------------------
module lts_core #(
    parameter int TIME_BITS = lts_pkg::DEF_TIME_BITS,
    parameter int POS_BITS  = lts_pkg::DEF_POS_BITS
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step_en,
    input  lts_pkg::item_t   item,
    input  lts_pkg::cfg_t    cfg,
    output lts_pkg::result_t result
);
    import lts_pkg::*;

    localparam int CW = 34;

    // Trial state
    state_t               state_reg,       state_next;
    logic                 entry_reg,       entry_next;
    logic [TIME_BITS-1:0] state_start_reg, state_start_next;
    logic [TIME_BITS-1:0] hold_start_reg,  hold_start_next;
    logic                 hold_active_reg, hold_active_next;
    logic [1:0]           type_reg,        type_next;
    logic [8:0]           cue_extra_reg,   cue_extra_next;
    logic [1:0]           outcome_reg,     outcome_next;
    logic [TIME_BITS-1:0] go_start_reg,    go_start_next;
    logic [TIME_BITS-1:0] cross_time_reg,  cross_time_next;
    logic [TIME_BITS-1:0] cue_start_reg,   cue_start_next;
    logic [1:0]           pulses_reg,      pulses_next;
    logic                 pulse_high_reg,  pulse_high_next;
    logic [TIME_BITS-1:0] last_toggle_reg, last_toggle_next;
    logic [2:0]           tone_reg,        tone_next;
    logic [1:0]           grating_reg,     grating_next;
    logic                 indicator_reg,   indicator_next;
    logic                 lock_reg,        lock_next;

    // Item decode
    logic [TIME_BITS-1:0]       now_val;
    logic signed [POS_BITS-1:0] pos_val;
    logic signed [POS_W-1:0]    pos_ext;
    logic [1:0]                 rtype_clamped;
    logic [7:0]                 rdelay_sat;
    logic [TIME_BITS-1:0]       elapsed;
    logic [TIME_BITS-1:0]       hold_elapsed;
    logic [TIME_BITS-1:0]       phase_elapsed;
    logic [TIME_BITS-1:0]       react_go;
    logic [TIME_BITS-1:0]       react_cue;
    logic [TIME_BITS-1:0]       react_sel;
    logic [15:0]                react_sat;
    logic signed [POS_W-1:0]    go_thr;
    logic signed [POS_W-1:0]    early_thr;
    logic                       past_go;
    logic                       past_early;
    logic [1:0]                 pulses_inc;
    logic [CW-1:0]              cue_wait;

    // Per-tick outputs that are not state
    logic [1:0]  torque;
    logic        rep;
    logic [1:0]  rep_out;
    logic [15:0] rep_rt;
    logic [POS_W-1:0] rep_pos;
    logic [1:0]  rep_lvl;

    assign now_val       = item.now_ms[TIME_BITS-1:0];
    assign pos_val       = item.position[POS_BITS-1:0];
    assign pos_ext       = POS_W'(pos_val);
    assign rtype_clamped = (item.random_type == 2'd3) ? 2'd2 : item.random_type;
    assign rdelay_sat    = (item.random_delay > CUE_DELAY_SPAN) ? CUE_DELAY_SPAN
                                                                 : item.random_delay;
    assign elapsed       = now_val - state_start_reg;
    assign hold_elapsed  = now_val - hold_start_reg;
    assign phase_elapsed = now_val - last_toggle_reg;
    assign go_thr        = POS_W'(signed'(cfg.go_threshold));
    assign early_thr     = POS_W'(signed'(cfg.early_threshold));
    assign past_go       = pos_ext < go_thr;
    assign past_early    = pos_ext < early_thr;
    assign pulses_inc    = pulses_reg + 2'd1;
    assign cue_wait      = CW'(cfg.cue_sound_ms) + CW'(cue_extra_reg);

    // Reaction time, saturated to 16 bits
    assign react_go  = cross_time_reg - go_start_reg;
    assign react_cue = cross_time_reg - cue_start_reg;
    always_comb begin
        priority if (outcome_reg == OUT_CORRECT) begin
            react_sel = react_go;
        end else if (outcome_reg == OUT_EARLY) begin
            react_sel = react_cue;
        end else begin
            react_sel = '0;
        end
    end
    assign react_sat = (CW'(react_sel) > CW'(16'hFFFF)) ? 16'hFFFF : react_sel[15:0];

    // Next state of one tick
    always_comb begin
        state_next       = state_reg;
        entry_next       = entry_reg;
        state_start_next = state_start_reg;
        hold_start_next  = hold_start_reg;
        hold_active_next = hold_active_reg;
        type_next        = type_reg;
        cue_extra_next   = cue_extra_reg;
        outcome_next     = outcome_reg;
        go_start_next    = go_start_reg;
        cross_time_next  = cross_time_reg;
        cue_start_next   = cue_start_reg;
        pulses_next      = pulses_reg;
        pulse_high_next  = pulse_high_reg;
        last_toggle_next = last_toggle_reg;
        tone_next        = tone_reg;
        grating_next     = grating_reg;
        indicator_next   = indicator_reg;
        lock_next        = lock_reg;
        torque           = TQ_NONE;
        rep              = 1'b0;
        rep_out          = OUT_CORRECT;
        rep_rt           = '0;
        rep_pos          = '0;
        rep_lvl          = '0;

        unique case (state_reg)
            ST_INIT: begin
                // Latch the draws for the coming trial
                if (entry_reg) begin
                    type_next        = rtype_clamped;
                    cue_extra_next   = CUE_DELAY_BASE + 9'(rdelay_sat);
                    outcome_next     = OUT_CORRECT;
                    go_start_next    = '0;
                    cross_time_next  = '0;
                    cue_start_next   = '0;
                    grating_next     = GRATING_NONE;
                    indicator_next   = 1'b0;
                    lock_next        = 1'b1;
                    hold_active_next = 1'b0;
                    entry_next       = 1'b0;
                end
                if (CW'(elapsed) >= CW'(INIT_WAIT_MS)) begin
                    state_next       = ST_CUE;
                    state_start_next = now_val;
                    entry_next       = 1'b1;
                    cue_start_next   = now_val;
                end
            end
            ST_CUE: begin
                if (entry_reg) begin
                    grating_next = type_reg + 2'd1;
                    tone_next    = {1'b0, type_reg} + 3'd1;
                    entry_next   = 1'b0;
                end
                // Early movement aborts the trial
                if (past_early) begin
                    outcome_next     = OUT_EARLY;
                    cross_time_next  = now_val;
                    tone_next        = TONE_OFF;
                    grating_next     = GRATING_NONE;
                    indicator_next   = 1'b1;
                    state_next       = ST_PENALTY;
                    state_start_next = now_val;
                    entry_next       = 1'b1;
                end else begin
                    if (CW'(elapsed) >= CW'(cfg.cue_sound_ms)) begin
                        tone_next = TONE_OFF;
                    end
                    if (CW'(elapsed) >= cue_wait) begin
                        lock_next        = 1'b0;
                        state_next       = ST_GO;
                        state_start_next = now_val;
                        entry_next       = 1'b1;
                        go_start_next    = now_val;
                    end
                end
            end
            ST_GO: begin
                if (entry_reg) begin
                    tone_next      = TONE_GO;
                    indicator_next = 1'b1;
                    entry_next     = 1'b0;
                end
                if (CW'(elapsed) >= CW'(GO_TONE_MS)) begin
                    tone_next = TONE_OFF;
                end
                torque = TQ_LOW;
                // Track the hold past the threshold; timeout unless rewarded
                if (past_go && hold_active_reg &&
                        CW'(hold_elapsed) >= CW'(cfg.hold_ms)) begin
                    cross_time_next  = now_val;
                    outcome_next     = OUT_CORRECT;
                    hold_active_next = 1'b0;
                    state_next       = ST_REWARD;
                    state_start_next = now_val;
                    entry_next       = 1'b1;
                end else begin
                    if (past_go && !hold_active_reg) begin
                        hold_active_next = 1'b1;
                        hold_start_next  = now_val;
                    end else if (!past_go) begin
                        hold_active_next = 1'b0;
                    end
                    if (CW'(elapsed) > CW'(cfg.go_timeout_ms)) begin
                        outcome_next     = OUT_TIMEOUT;
                        cross_time_next  = '0;
                        hold_active_next = 1'b0;
                        state_next       = ST_TIMEOUT;
                        state_start_next = now_val;
                        entry_next       = 1'b1;
                    end
                end
            end
            ST_REWARD: begin
                // Start the first pulse, then alternate phases
                if (entry_reg) begin
                    entry_next       = 1'b0;
                    pulses_next      = '0;
                    pulse_high_next  = 1'b1;
                    tone_next        = TONE_REWARD;
                    last_toggle_next = now_val;
                end else if (CW'(phase_elapsed) >= CW'(cfg.reward_phase_ms)) begin
                    if (pulse_high_reg) begin
                        pulse_high_next  = 1'b0;
                        tone_next        = TONE_OFF;
                        last_toggle_next = now_val;
                    end else begin
                        pulses_next = pulses_inc;
                        if ({1'b0, pulses_inc} < ({1'b0, type_reg} + 3'd1)) begin
                            pulse_high_next  = 1'b1;
                            tone_next        = TONE_REWARD;
                            last_toggle_next = now_val;
                        end else begin
                            state_next       = ST_RESET;
                            state_start_next = now_val;
                            entry_next       = 1'b1;
                        end
                    end
                end
            end
            ST_PENALTY: begin
                if (entry_reg) begin
                    tone_next      = TONE_PENALTY;
                    grating_next   = GRATING_NONE;
                    indicator_next = 1'b0;
                    entry_next     = 1'b0;
                end
                if (CW'(elapsed) >= CW'(RESULT_SOUND_MS)) begin
                    tone_next = TONE_OFF;
                end
                if (CW'(elapsed) >= CW'(cfg.penalty_ms)) begin
                    state_next       = ST_RESET;
                    state_start_next = now_val;
                    entry_next       = 1'b1;
                end
            end
            ST_TIMEOUT: begin
                if (entry_reg) begin
                    tone_next  = TONE_TIMEOUT;
                    entry_next = 1'b0;
                end
                if (CW'(elapsed) >= CW'(RESULT_SOUND_MS)) begin
                    tone_next = TONE_OFF;
                end
                if (CW'(elapsed) >= CW'(TIMEOUT_STATE_MS)) begin
                    state_next       = ST_RESET;
                    state_start_next = now_val;
                    entry_next       = 1'b1;
                end
            end
            default: begin
                // Report the trial on the first tick, wait for the lever home
                if (entry_reg) begin
                    grating_next = GRATING_NONE;
                    rep          = 1'b1;
                    rep_out      = outcome_reg;
                    rep_rt       = react_sat;
                    rep_pos      = pos_ext;
                    rep_lvl      = type_reg;
                    torque       = TQ_HIGH;
                    entry_next   = 1'b0;
                end
                state_next = ST_RESET;
                if (!pos_ext[POS_W-1] && CW'(elapsed) >= CW'(cfg.rest_wait_ms)) begin
                    state_next       = ST_INIT;
                    state_start_next = now_val;
                    entry_next       = 1'b1;
                end
            end
        endcase
    end

    // Hold state between ticks, advance on each step
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_INIT;
            entry_reg       <= 1'b1;
            state_start_reg <= '0;
            hold_start_reg  <= '0;
            hold_active_reg <= 1'b0;
            type_reg        <= '0;
            cue_extra_reg   <= '0;
            outcome_reg     <= OUT_CORRECT;
            go_start_reg    <= '0;
            cross_time_reg  <= '0;
            cue_start_reg   <= '0;
            pulses_reg      <= '0;
            pulse_high_reg  <= 1'b0;
            last_toggle_reg <= '0;
            tone_reg        <= TONE_OFF;
            grating_reg     <= GRATING_NONE;
            indicator_reg   <= 1'b0;
            lock_reg        <= 1'b0;
        end else if (step_en) begin
            state_reg       <= state_next;
            entry_reg       <= entry_next;
            state_start_reg <= state_start_next;
            hold_start_reg  <= hold_start_next;
            hold_active_reg <= hold_active_next;
            type_reg        <= type_next;
            cue_extra_reg   <= cue_extra_next;
            outcome_reg     <= outcome_next;
            go_start_reg    <= go_start_next;
            cross_time_reg  <= cross_time_next;
            cue_start_reg   <= cue_start_next;
            pulses_reg      <= pulses_next;
            pulse_high_reg  <= pulse_high_next;
            last_toggle_reg <= last_toggle_next;
            tone_reg        <= tone_next;
            grating_reg     <= grating_next;
            indicator_reg   <= indicator_next;
            lock_reg        <= lock_next;
        end
    end

    // Result of this tick
    always_comb begin
        result.trial_state     = state_code(state_next);
        result.reward_pin      = pulse_high_next;
        result.tone_code       = tone_next;
        result.grating_code    = grating_next;
        result.indicator_on    = indicator_next;
        result.lever_lock      = lock_next;
        result.torque_cmd      = torque;
        result.report_valid    = rep;
        result.outcome         = rep_out;
        result.reaction_ms     = rep_rt;
        result.report_position = rep_pos;
        result.report_level    = rep_lvl;
    end

endmodule

// ===== hdl/lever_trial_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// lever_trial_sequencer_top: lever task trial sequencer
// Input register, trial state machine, result register and config registers.
// ----------------------------------------------------------------------------
// One tick item enters per clock and gives one result item. An accepted item
// is held in the input register while the state machine steps it in a single
// pass of logic; the result register loads on that step and raises m_tvalid.
// One item per cycle is sustained while m_tready stays high; a held result
// stalls the step, and s_tready drops once the input register is full as well.
// All timing is measured on the now_ms field of the items, never on the clock.
// The user must write configuration registers only while no item is in flight;
// the block itself does not enforce it.
module lever_trial_sequencer_top #(
    parameter int TIME_BITS = lts_pkg::DEF_TIME_BITS,
    parameter int POS_BITS  = lts_pkg::DEF_POS_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // now_ms[31:0], position[63:32], random_type[65:64], random_delay[73:66]
    input  logic [lts_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // trial_state[2:0], reward_pin[3], tone_code[6:4], grating_code[8:7],
    // indicator_on[9], lever_lock[10], torque_cmd[12:11], report_valid[13],
    // outcome[15:14], reaction_ms[31:16], report_position[63:32],
    // report_level[65:64]
    output logic [lts_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic                          cfg_we,
    input  logic [lts_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lts_pkg::CFG_W-1:0]     cfg_wdata
);
    import lts_pkg::*;

    cfg_t    cfg;
    item_t   item_reg;
    logic    in_valid_reg;
    result_t step_result;
    result_t res_reg;
    logic    res_valid_reg;
    logic    step_fire;

    lts_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Step when an item waits and the result register is empty or being taken
    assign step_fire = in_valid_reg && (!res_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || step_fire;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.now_ms       <= s_tdata[31:0];
            item_reg.position     <= s_tdata[63:32];
            item_reg.random_type  <= s_tdata[65:64];
            item_reg.random_delay <= s_tdata[73:66];
        end
    end

    lts_core #(
        .TIME_BITS (TIME_BITS),
        .POS_BITS  (POS_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_fire),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    // Result register: load on a step, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (step_fire) begin
            res_valid_reg <= 1'b1;
        end else if (m_tready) begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_fire) begin
            res_reg <= step_result;
        end
    end

    assign m_tvalid = res_valid_reg;
    assign m_tdata  = {6'd0,
                       res_reg.report_level,
                       res_reg.report_position,
                       res_reg.reaction_ms,
                       res_reg.outcome,
                       res_reg.report_valid,
                       res_reg.torque_cmd,
                       res_reg.lever_lock,
                       res_reg.indicator_on,
                       res_reg.grating_code,
                       res_reg.tone_code,
                       res_reg.reward_pin,
                       res_reg.trial_state};

`ifndef SYNTH
    // A report comes out in reset, or on the tick that already leaves it
    a_report_in_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid_reg && res_reg.report_valid) |->
            (res_reg.trial_state == TS_RESET || res_reg.trial_state == TS_INIT))
        else $error("report outside reset state");

    // High torque request goes with the report and nothing else
    a_torque_report: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid_reg |-> ((res_reg.torque_cmd == TQ_HIGH) == res_reg.report_valid))
        else $error("high torque request without report");

    // An empty result register never stalls the input
    a_no_stall_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !res_valid_reg |-> s_tready)
        else $error("input stalled with empty result register");

    // Every step loads a result
    a_step_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        step_fire |=> res_valid_reg)
        else $error("step without result");
`endif

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: regression bench for the lever trial sequencer
// Streams tick items into the block and keeps a local model of the trial
// state machine. Each result item is compared field by field against the
// model's prediction. Several register settings are covered, extremes
// included, with random idle cycles on both stream sides.
// ----------------------------------------------------------------------------
module testbench;
    import lts_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_GAP     = 17;

    // Tick item as packed on s_tdata, lowest field last
    typedef struct packed {
        logic [5:0]  zero_fill;
        logic [7:0]  random_delay;
        logic [1:0]  random_type;
        logic [31:0] position;
        logic [31:0] now_ms;
    } tick_word_t;

    // Status item as packed on m_tdata, lowest field last
    typedef struct packed {
        logic [5:0]  zero_fill;
        logic [1:0]  report_level;
        logic [31:0] report_position;
        logic [15:0] reaction_ms;
        logic [1:0]  outcome;
        logic        report_valid;
        logic [1:0]  torque_cmd;
        logic        lever_lock;
        logic        indicator_on;
        logic [1:0]  grating_code;
        logic [2:0]  tone_code;
        logic        reward_pin;
        logic [2:0]  trial_state;
    } status_word_t;

    // How the stimulus steers the lever through the coming trial
    typedef enum int {PLAN_REWARD, PLAN_EARLY, PLAN_TIMEOUT} trial_plan_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]      cfg_wdata;

    lever_trial_sequencer_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Register copy, indexed by register number
    logic [15:0] timing_regs [8] = '{RST_GO_THRESHOLD, RST_EARLY_THRESHOLD, RST_HOLD_MS,
                                     RST_GO_TIMEOUT_MS, RST_PENALTY_MS, RST_REST_WAIT_MS,
                                     RST_CUE_SOUND_MS, RST_REWARD_PHASE_MS};

    // Trial state of the local model
    logic [2:0]  seq_state     = TS_INIT;
    logic        entry_due     = 1'b1;
    logic [31:0] state_t0      = '0;
    logic [31:0] hold_t0       = '0;
    logic        holding       = 1'b0;
    logic [1:0]  trial_level   = '0;
    logic [8:0]  cue_extra     = '0;
    logic [1:0]  trial_result  = OUT_CORRECT;
    logic [31:0] go_t0         = '0;
    logic [31:0] cross_ms      = '0;
    logic [31:0] cue_t0        = '0;
    logic [1:0]  pulse_cnt     = '0;
    logic        pin_level     = 1'b0;
    logic [31:0] toggle_t      = '0;
    logic [2:0]  tone_now      = TONE_OFF;
    logic [1:0]  grating_now   = GRATING_NONE;
    logic        indicator_now = 1'b0;
    logic        lock_now      = 1'b0;

    status_word_t expected_status [$];
    logic [31:0]  now_cur     = '0;
    bit           quiet_mode  = 1'b0;
    trial_plan_t  trial_plan  = PLAN_REWARD;
    int           mismatches  = 0;
    int unsigned  cycle_count = 0;

    // Clock
    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // Abort a run that hangs
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("lever_trial_sequencer_top regression: fail");
            $finish;
        end
    end

    // Move the model to a new state and restart its timer
    function automatic void enter_state(input logic [2:0] st, input logic [31:0] now);
        seq_state = st;
        state_t0  = now;
        entry_due = 1'b1;
    endfunction

    // Advance the model by one tick and build the status it should produce
    task automatic predict_tick(input tick_word_t t, output status_word_t r);
        logic [31:0]        now;
        logic [31:0]        el;
        logic [31:0]        held;
        logic [31:0]        span;
        logic [31:0]        lag;
        logic signed [31:0] pos;
        logic [1:0]         torque;
        logic               rewarded;
        now      = t.now_ms;
        pos      = t.position;
        el       = now - state_t0;
        r        = '0;
        torque   = TQ_NONE;
        rewarded = 1'b0;
        case (seq_state)
            TS_INIT: begin
                // latch the draws for the coming trial, clamped to their ranges
                if (entry_due) begin
                    trial_level  = (t.random_type > 2'd2) ? 2'd2 : t.random_type;
                    cue_extra    = CUE_DELAY_BASE +
                        9'((t.random_delay > CUE_DELAY_SPAN) ? CUE_DELAY_SPAN
                                                             : t.random_delay);
                    trial_result = OUT_CORRECT;
                    go_t0        = '0;
                    cross_ms     = '0;
                    cue_t0       = '0;
                    grating_now  = GRATING_NONE;
                    indicator_now = 1'b0;
                    lock_now     = 1'b1;
                    holding      = 1'b0;
                    entry_due    = 1'b0;
                end
                if (el >= 32'(INIT_WAIT_MS)) begin
                    enter_state(TS_CUE, now);
                    cue_t0 = now;
                end
            end
            TS_CUE: begin
                if (entry_due) begin
                    grating_now = trial_level + 2'd1;
                    tone_now    = {1'b0, trial_level} + 3'd1;
                    entry_due   = 1'b0;
                end
                // early movement ends the trial at once
                if (pos < 32'($signed(timing_regs[REG_EARLY_THRESHOLD]))) begin
                    trial_result  = OUT_EARLY;
                    cross_ms      = now;
                    tone_now      = TONE_OFF;
                    grating_now   = GRATING_NONE;
                    indicator_now = 1'b1;
                    enter_state(TS_PENALTY, now);
                end else begin
                    span = 32'(timing_regs[REG_CUE_SOUND_MS]) + 32'(cue_extra);
                    if (el >= 32'(timing_regs[REG_CUE_SOUND_MS]))
                        tone_now = TONE_OFF;
                    if (el >= span) begin
                        lock_now = 1'b0;
                        enter_state(TS_GO, now);
                        go_t0 = now;
                    end
                end
            end
            TS_GO: begin
                if (entry_due) begin
                    tone_now      = TONE_GO;
                    indicator_now = 1'b1;
                    entry_due     = 1'b0;
                end
                if (el >= 32'(GO_TONE_MS))
                    tone_now = TONE_OFF;
                torque = TQ_LOW;
                // the hold timer runs only while the lever stays pushed
                if (pos < 32'($signed(timing_regs[REG_GO_THRESHOLD]))) begin
                    held = now - hold_t0;
                    if (!holding) begin
                        holding = 1'b1;
                        hold_t0 = now;
                    end else if (held >= 32'(timing_regs[REG_HOLD_MS])) begin
                        cross_ms     = now;
                        trial_result = OUT_CORRECT;
                        holding      = 1'b0;
                        rewarded     = 1'b1;
                        enter_state(TS_REWARD, now);
                    end
                end else begin
                    holding = 1'b0;
                end
                if (!rewarded && el > 32'(timing_regs[REG_GO_TIMEOUT_MS])) begin
                    trial_result = OUT_TIMEOUT;
                    cross_ms     = '0;
                    holding      = 1'b0;
                    enter_state(TS_TIMEOUT, now);
                end
            end
            TS_REWARD: begin
                if (entry_due) begin
                    entry_due = 1'b0;
                    pulse_cnt = '0;
                    pin_level = 1'b1;
                    tone_now  = TONE_REWARD;
                    toggle_t  = now;
                end else begin
                    lag = now - toggle_t;
                    // alternate high and low phases, level+1 pulses in all
                    if (lag >= 32'(timing_regs[REG_REWARD_PHASE_MS])) begin
                        if (pin_level) begin
                            pin_level = 1'b0;
                            tone_now  = TONE_OFF;
                            toggle_t  = now;
                        end else begin
                            pulse_cnt = pulse_cnt + 2'd1;
                            if (pulse_cnt <= trial_level) begin
                                pin_level = 1'b1;
                                tone_now  = TONE_REWARD;
                                toggle_t  = now;
                            end else begin
                                enter_state(TS_RESET, now);
                            end
                        end
                    end
                end
            end
            TS_PENALTY: begin
                if (entry_due) begin
                    tone_now      = TONE_PENALTY;
                    grating_now   = GRATING_NONE;
                    indicator_now = 1'b0;
                    entry_due     = 1'b0;
                end
                if (el >= 32'(RESULT_SOUND_MS))
                    tone_now = TONE_OFF;
                if (el >= 32'(timing_regs[REG_PENALTY_MS]))
                    enter_state(TS_RESET, now);
            end
            TS_TIMEOUT: begin
                if (entry_due) begin
                    tone_now  = TONE_TIMEOUT;
                    entry_due = 1'b0;
                end
                if (el >= 32'(RESULT_SOUND_MS))
                    tone_now = TONE_OFF;
                if (el >= 32'(TIMEOUT_STATE_MS))
                    enter_state(TS_RESET, now);
            end
            default: begin
                // report the trial on the first tick in reset
                if (entry_due) begin
                    grating_now = GRATING_NONE;
                    lag = '0;
                    if (trial_result == OUT_CORRECT)
                        lag = cross_ms - go_t0;
                    else if (trial_result == OUT_EARLY)
                        lag = cross_ms - cue_t0;
                    r.report_valid    = 1'b1;
                    r.outcome         = trial_result;
                    r.reaction_ms     = (lag > 32'hFFFF) ? 16'hFFFF : lag[15:0];
                    r.report_position = t.position;
                    r.report_level    = trial_level;
                    torque            = TQ_HIGH;
                    entry_due         = 1'b0;
                end
                seq_state = TS_RESET;
                if (pos >= 0 && el >= 32'(timing_regs[REG_REST_WAIT_MS]))
                    enter_state(TS_INIT, now);
            end
        endcase
        r.trial_state  = seq_state;
        r.reward_pin   = pin_level;
        r.tone_code    = tone_now;
        r.grating_code = grating_now;
        r.indicator_on = indicator_now;
        r.lever_lock   = lock_now;
        r.torque_cmd   = torque;
    endtask

    // Offer one tick item after a random gap and predict its status
    task automatic send_tick(input logic [31:0] now, input logic [31:0] pos,
                             input logic [1:0] rtype, input logic [7:0] rdelay);
        tick_word_t   t;
        status_word_t want;
        int           gap;
        t = '{zero_fill: '0, random_delay: rdelay, random_type: rtype,
              position: pos, now_ms: now};
        gap = quiet_mode ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= t;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (s_tready !== 1'b1);
        predict_tick(t, want);
        expected_status.push_back(want);
        now_cur = now;
    endtask

    // Hold the sender until every predicted status has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_status.size() > 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write all eight registers back to back while the block is idle
    task automatic program_registers(input logic [15:0] go_thr, input logic [15:0] early_thr,
                                     input logic [15:0] hold, input logic [15:0] go_limit,
                                     input logic [15:0] penalty, input logic [15:0] rest,
                                     input logic [15:0] cue_tone, input logic [15:0] phase);
        logic [15:0] vals [8];
        drain_results();
        vals[REG_GO_THRESHOLD]    = go_thr;
        vals[REG_EARLY_THRESHOLD] = early_thr;
        vals[REG_HOLD_MS]         = hold;
        vals[REG_GO_TIMEOUT_MS]   = go_limit;
        vals[REG_PENALTY_MS]      = penalty;
        vals[REG_REST_WAIT_MS]    = rest;
        vals[REG_CUE_SOUND_MS]    = cue_tone;
        vals[REG_REWARD_PHASE_MS] = phase;
        for (int i = 0; i < 8; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= i[CFG_IDX_W-1:0];
            cfg_wdata <= vals[i];
            @(posedge aclk);
            timing_regs[i] = vals[i];
        end
        cfg_we <= 1'b0;
    endtask

    // Pick a lever position that fits the current state and trial plan
    function automatic int lever_position();
        int go_thr;
        int early_thr;
        int home;
        int roll;
        int r;
        go_thr    = int'($signed(timing_regs[REG_GO_THRESHOLD]));
        early_thr = int'($signed(timing_regs[REG_EARLY_THRESHOLD]));
        roll      = $urandom_range(0, 99);
        r         = $urandom_range(0, 500);
        if (roll < 10)
            return $urandom;
        case (seq_state)
            TS_CUE: begin
                home = (early_thr > 0) ? early_thr : 0;
                if (trial_plan == PLAN_EARLY && roll < 40)
                    return early_thr - 1 - r;
                return home + r;
            end
            TS_GO: begin
                if (trial_plan == PLAN_TIMEOUT)
                    return (roll < 20) ? go_thr - 1 - r : go_thr + r;
                return (roll < 85) ? go_thr - 1 - r : go_thr + r;
            end
            TS_RESET:
                return (roll < 75) ? r : -1 - r;
            default:
                return r;
        endcase
    endfunction

    // Random ticks: mostly well-formed trials, with time jumps and noise
    task automatic run_random_ticks(input int count, input int step_max);
        int          sel;
        int          advance_ms;
        logic [31:0] now;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 24) == 0)
                quiet_mode = !quiet_mode;
            if (seq_state == TS_INIT) begin
                sel = $urandom_range(0, 99);
                if (sel < 15)
                    trial_plan = PLAN_EARLY;
                else if (sel < 35)
                    trial_plan = PLAN_TIMEOUT;
                else
                    trial_plan = PLAN_REWARD;
            end
            sel = $urandom_range(0, 99);
            if (sel < 70)
                advance_ms = $urandom_range(0, step_max);
            else if (sel < 95)
                advance_ms = $urandom_range(0, 25 * step_max);
            else
                advance_ms = $urandom_range(0, 70000);
            now = (sel >= 98) ? $urandom : now_cur + advance_ms;
            send_tick(now, lever_position(), 2'($urandom_range(0, 3)),
                      8'($urandom_range(0, 255)));
        end
    endtask

    // Hand-picked trials under reset settings: early, rewarded, timed out
    task automatic test_directed_trials();
        // first init wait counts from time zero; type 3 and delay 255 clamp
        send_tick(32'd0,    32'd0,         2'd3, 8'd255);
        send_tick(32'd250,  32'h7FFF_FFFF, 2'd0, 8'd0);
        send_tick(32'd260,  32'd100,       2'd1, 8'd17);
        send_tick(32'd300,  32'h8000_0000, 2'd2, 8'd200);
        send_tick(32'd302,  32'd0,         2'd0, 8'd0);
        send_tick(32'd2302, 32'd0,         2'd0, 8'd0);
        // report with the lever not home, then release
        send_tick(32'd2304, 32'hFFFF_FFFF, 2'd0, 8'd0);
        send_tick(32'd4000, 32'd0,         2'd0, 8'd0);
        send_tick(32'd4002, 32'd0,         2'd0, 8'd0);
        send_tick(32'd4252, 32'd3,         2'd0, 8'd0);
        // exactly on the early threshold is not early
        send_tick(32'd4254, 32'hFFFF_FFF7, 2'd0, 8'd0);
        send_tick(32'd4754, 32'd0,         2'd0, 8'd0);
        send_tick(32'd5004, 32'd0,         2'd0, 8'd0);
        // hold, let go on the threshold, hold again to reward
        send_tick(32'd5006, -32'sd28,      2'd0, 8'd0);
        send_tick(32'd5100, -32'sd27,      2'd0, 8'd0);
        send_tick(32'd5110, -32'sd28,      2'd0, 8'd0);
        send_tick(32'd5262, -32'sd100,     2'd0, 8'd0);
        send_tick(32'd5264, 32'd0,         2'd0, 8'd0);
        send_tick(32'd5764, 32'd0,         2'd0, 8'd0);
        send_tick(32'd6264, 32'd0,         2'd0, 8'd0);
        send_tick(32'd6266, 32'd5,         2'd0, 8'd0);
        send_tick(32'd7766, 32'd5,         2'd0, 8'd0);
        // timestamp wraps through zero, go times out
        send_tick(32'hFFFF_FF00, 32'd0,    2'd1, 8'd200);
        send_tick(32'h0000_0400, 32'd0,    2'd0, 8'd0);
        send_tick(32'h0000_0E28, 32'd0,    2'd0, 8'd0);
        send_tick(32'h0000_0E2A, 32'd0,    2'd0, 8'd0);
        send_tick(32'h0000_101E, 32'd0,    2'd0, 8'd0);
        send_tick(32'h0000_1020, 32'd7,    2'd0, 8'd0);
    endtask

    // Reset settings, with a full drain halfway through
    task automatic test_default_timing();
        run_random_ticks(60, 120);
        drain_results();
        run_random_ticks(60, 120);
    endtask

    // All times zero, shortest reward phase, thresholds at their extremes
    task automatic test_zero_timing();
        program_registers(16'h8000, 16'h7FFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1);
        run_random_ticks(120, 30);
    endtask

    // All times at their maximum, thresholds swapped to the other extremes
    task automatic test_max_timing();
        program_registers(16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                          16'hFFFF, 16'hFFFF);
        run_random_ticks(60, 3000);
    endtask

    // Two random settings in a realistic range
    task automatic test_mixed_timing();
        for (int n = 0; n < 2; n++) begin
            program_registers(16'($urandom_range(0, 4000) - 2000),
                              16'($urandom_range(0, 4000) - 2000),
                              16'($urandom_range(0, 400)), 16'($urandom_range(0, 3000)),
                              16'($urandom_range(0, 3000)), 16'($urandom_range(0, 3000)),
                              16'($urandom_range(0, 1000)), 16'($urandom_range(1, 800)));
            run_random_ticks(60, 100);
        end
    endtask

    // Any register value at all, but never a zero reward phase
    task automatic test_random_registers();
        program_registers(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom_range(1, 65535)));
        run_random_ticks(80, 4000);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // Take status items with random stalls and compare with the predictions
    initial begin : status_monitor
        int           stall;
        status_word_t got;
        status_word_t want;
        m_tready <= 1'b0;
        while (aresetn !== 1'b1)
            @(posedge aclk);
        forever begin
            stall = quiet_mode ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid === 1'b1 && m_tready === 1'b1));
            got = m_tdata;
            if (expected_status.size() == 0) begin
                $error("status item with no prediction pending: 0x%0h", got);
                mismatches++;
            end else begin
                want = expected_status.pop_front();
                check_field("trial_state", 32'(want.trial_state), 32'(got.trial_state));
                check_field("reward_pin", 32'(want.reward_pin), 32'(got.reward_pin));
                check_field("tone_code", 32'(want.tone_code), 32'(got.tone_code));
                check_field("grating_code", 32'(want.grating_code),
                            32'(got.grating_code));
                check_field("indicator_on", 32'(want.indicator_on),
                            32'(got.indicator_on));
                check_field("lever_lock", 32'(want.lever_lock), 32'(got.lever_lock));
                check_field("torque_cmd", 32'(want.torque_cmd), 32'(got.torque_cmd));
                check_field("report_valid", 32'(want.report_valid),
                            32'(got.report_valid));
                check_field("outcome", 32'(want.outcome), 32'(got.outcome));
                check_field("reaction_ms", 32'(want.reaction_ms), 32'(got.reaction_ms));
                check_field("report_position", want.report_position, got.report_position);
                check_field("report_level", 32'(want.report_level),
                            32'(got.report_level));
            end
        end
    end

    // Reset, run the tests in turn, then drain and decide
    initial begin
        int waited;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_trials();
        test_default_timing();
        test_zero_timing();
        test_max_timing();
        test_mixed_timing();
        test_random_registers();

        s_tvalid <= 1'b0;
        waited = 0;
        while (expected_status.size() > 0 && waited < 4000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (8) @(posedge aclk);
        if (expected_status.size() > 0) begin
            $error("%0d predicted status items never arrived", expected_status.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("lever_trial_sequencer_top regression: pass");
        else
            $display("lever_trial_sequencer_top regression: fail");
        $finish;
    end

endmodule
